// ===== design/tiac_pkg.sv =====
// Package for the telnet IAC filter: telnet codes, sequence state type,
// config register map and the decode result struct.
// No dependencies.
package tiac_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 1;
  localparam int unsigned ApbDataW = 32;

  // Telnet codes
  localparam logic [ByteW-1:0] IacCode  = 8'hFF;
  localparam logic [ByteW-1:0] CmdDont  = 8'hFE;
  localparam logic [ByteW-1:0] CmdDo    = 8'hFD;
  localparam logic [ByteW-1:0] CmdWont  = 8'hFC;
  localparam logic [ByteW-1:0] CmdWill  = 8'hFB;
  localparam logic [ByteW-1:0] NulByte  = 8'h00;

  // Register map
  localparam logic [AddrW-1:0] RegZeroFill   = 1'b0;
  localparam logic [ByteW-1:0] ZeroFillReset = 8'h20;

  // Output kinds
  localparam logic KindData  = 1'b0;
  localparam logic KindReply = 1'b1;

  // Reply byte index within a three-byte refusal
  localparam logic [1:0] PhaseIac   = 2'd0;
  localparam logic [1:0] PhaseReply = 2'd1;
  localparam logic [1:0] PhaseOpt   = 2'd2;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_IAC  = 2'd1,
    SEQ_NEG  = 2'd2
  } seq_e;

  typedef struct packed {
    logic             has_result;  // current phase produces an item
    logic             done;        // input item fully handled after this phase
    logic             kind;
    logic [ByteW-1:0] data;
    logic             last;
    seq_e             seq_nx;
    logic [ByteW-1:0] cmd_nx;
  } dec_t;

endpackage

// ===== design/tiac_decode.sv =====
// Combinational decode of one held byte against the sequence state.
// Depends on tiac_pkg.
module tiac_decode (
  input  logic [7:0]    byte_i,
  input  logic          eoc_i,
  input  tiac_pkg::seq_e seq_i,
  input  logic [7:0]    cmd_i,
  input  logic [7:0]    fill_i,
  input  logic [1:0]    phase_i,
  output tiac_pkg::dec_t dec_o
);
  import tiac_pkg::*;

  logic       is_neg;
  logic [1:0] nres;
  logic [7:0] reply;

  assign is_neg = (byte_i == CmdWill) || (byte_i == CmdWont) ||
                  (byte_i == CmdDo)   || (byte_i == CmdDont);
  assign reply  = ((cmd_i == CmdWill) || (cmd_i == CmdWont)) ? CmdDont : CmdWont;

  always_comb begin
    nres          = 2'd0;
    dec_o.seq_nx  = seq_i;
    dec_o.cmd_nx  = cmd_i;
    if (byte_i == NulByte) begin
      nres = 2'd1;
    end else begin
      unique case (seq_i)
        SEQ_IDLE: begin
          if (byte_i == IacCode) begin
            dec_o.seq_nx = SEQ_IAC;
          end else begin
            nres = 2'd1;
          end
        end
        SEQ_IAC: begin
          if (is_neg) begin
            dec_o.seq_nx = SEQ_NEG;
            dec_o.cmd_nx = byte_i;
          end else if (byte_i == IacCode) begin
            nres         = 2'd1;
            dec_o.seq_nx = SEQ_IDLE;
          end else begin
            dec_o.seq_nx = SEQ_IDLE;  // unknown command: swallow
          end
        end
        default: begin
          nres         = 2'd3;
          dec_o.seq_nx = SEQ_IDLE;
        end
      endcase
    end
    if (eoc_i) begin
      dec_o.seq_nx = SEQ_IDLE;
      dec_o.cmd_nx = NulByte;
    end

    dec_o.has_result = (nres != 2'd0);
    if (nres == 2'd3) begin
      dec_o.kind = KindReply;
      dec_o.last = (phase_i == PhaseOpt);
      dec_o.done = (phase_i == PhaseOpt);
      case (phase_i)
        PhaseIac:   dec_o.data = IacCode;
        PhaseReply: dec_o.data = reply;
        default:    dec_o.data = byte_i;
      endcase
    end else begin
      dec_o.kind = KindData;
      dec_o.last = 1'b1;
      dec_o.done = 1'b1;
      dec_o.data = (byte_i == NulByte) ? fill_i : byte_i;
    end
  end

endmodule

// ===== design/telnet_iac_filter.sv =====
// Top level of the telnet IAC filter: input register, decode, output register
// and the APB fill-byte register. Depends on tiac_pkg and tiac_decode.
//
// Received telnet bytes enter on the slave stream (tlast marks the end of a
// chunk) and leave on the master stream, with tuser telling a host data byte
// (0) from a reply byte for the link (1) and tlast flagging the last output
// caused by an input byte. Zero bytes come out as the fill byte (register at
// address 0, 0x20 after reset); IAC WILL/WONT and IAC DO/DONT are refused with
// three reply bytes; IAC IAC gives one 0xFF data byte; other commands are
// dropped. A byte that yields at most one output retires as that output loads,
// or at once if it has none, so the block sustains one byte per cycle while the
// output is not stalled; a refusal loads its reply bytes one at a time into the
// output register and holds the input register until the third one loads.
// Write the fill byte only while the block is idle.
module telnet_iac_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] in_byte
  input  logic                          s_axis_tlast,   // end_of_chunk
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] out_byte
  output logic                          m_axis_tuser,   // [0] out_kind
  output logic                          m_axis_tlast,   // out_last
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tiac_pkg::AddrW-1:0]    paddr,
  input  logic [tiac_pkg::ApbDataW-1:0] pwdata,
  output logic [tiac_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import tiac_pkg::*;

  // held input item
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  // sequence state
  seq_e       seq_q, seq_d;
  logic [7:0] cmd_q, cmd_d;
  logic [1:0] phase_q, phase_d;
  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_kind_q, out_last_q;
  // config
  logic [7:0] fill_q, fill_d;

  dec_t dec;
  logic out_room, out_load, consume, cfg_wr;

  tiac_decode u_decode (
    .byte_i  (in_byte_q),
    .eoc_i   (in_last_q),
    .seq_i   (seq_q),
    .cmd_i   (cmd_q),
    .fill_i  (fill_q),
    .phase_i (phase_q),
    .dec_o   (dec)
  );

  // Output register frees up when empty or when its item is taken now.
  assign out_room = !out_valid_q || m_axis_tready;
  assign out_load = in_valid_q && dec.has_result && out_room;
  // Retire the held byte once its last output loads, or at once if it has none.
  assign consume  = in_valid_q && dec.done && (!dec.has_result || out_room);
  assign s_axis_tready = !in_valid_q || consume;

  always_comb begin
    in_valid_d = s_axis_tready ? s_axis_tvalid : in_valid_q;
    seq_d      = consume ? dec.seq_nx : seq_q;
    cmd_d      = consume ? dec.cmd_nx : cmd_q;
    // advance through the three reply bytes, reset when the byte retires
    if (consume) begin
      phase_d = PhaseIac;
    end else if (out_load) begin
      phase_d = phase_q + 2'd1;
    end else begin
      phase_d = phase_q;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    fill_d = cfg_wr ? pwdata[7:0] : fill_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      seq_q       <= SEQ_IDLE;
      cmd_q       <= NulByte;
      phase_q     <= PhaseIac;
      out_valid_q <= 1'b0;
      fill_q      <= ZeroFillReset;
    end else begin
      in_valid_q  <= in_valid_d;
      seq_q       <= seq_d;
      cmd_q       <= cmd_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (out_load) begin
      out_byte_q <= dec.data;
      out_kind_q <= dec.kind;
      out_last_q <= dec.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // APB: single register, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == RegZeroFill);
  assign prdata = (paddr == RegZeroFill) ? {{(ApbDataW-8){1'b0}}, fill_q} : '0;

  // A partly sent refusal always has its input byte still held.
  a_phase_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhaseIac) |-> in_valid_q)
    else $error("reply phase without held byte");

  // Mid-refusal outputs are reply bytes and never the last one.
  a_phase_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhaseIac) && out_valid_q |-> (out_kind_q == KindReply) && !out_last_q)
    else $error("mid-refusal output not a reply");

  // Chunk end clears the sequence state.
  a_chunk_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_last_q |=> (seq_q == SEQ_IDLE) && (cmd_q == NulByte))
    else $error("sequence survived chunk end");

  // Loading a new output never overwrites one that was not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("output overwritten");

endmodule

// ===== tb/telnet_iac_filter_tb.sv =====
// Self-checking testbench for telnet_iac_filter: drives received bytes on the
// input stream, predicts the data and refusal bytes, and checks the output stream.
// Depends on tiac_pkg and the design files of telnet_iac_filter.
`timescale 1ns / 100ps

module telnet_iac_filter_tb;
  import tiac_pkg::*;

  // Settle time covers the input and output registers plus margin for a refusal in flight.
  localparam int LatencyCycles = 2;
  localparam int SettleCycles  = LatencyCycles + 6;
  localparam int RandomItems   = 420;

  typedef struct {
    logic             kind;
    logic [ByteW-1:0] data;
    logic             last;
  } out_byte_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [7:0] in_byte
  logic                s_axis_tlast;   // end_of_chunk
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;   // [7:0] out_byte
  logic                m_axis_tuser;   // [0] out_kind
  logic                m_axis_tlast;   // out_last
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Predictor state: sequence position, held negotiation command, fill byte.
  seq_e             seq_st;
  logic [ByteW-1:0] held_cmd;
  logic [ByteW-1:0] fill_byte;

  out_byte_t pending_out_q[$];
  int        err_count;
  int        bytes_sent;
  int        results_checked;
  int        refusals_seen;
  int        fill_writes;
  bit        in_gaps_on;
  bit        out_stall_on;

  telnet_iac_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on either stream.
  initial begin
    #400000;
    $display("telnet_iac_filter_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void queue_result(logic kind, logic [ByteW-1:0] data, logic last);
    out_byte_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    pending_out_q.insert(pending_out_q.size(), r);
  endfunction

  // Advance the filter state by one accepted byte and queue what it emits.
  function automatic void filter_byte(logic [ByteW-1:0] b, logic eoc);
    logic [ByteW-1:0] reply;
    if (b == NulByte) begin
      // A zero always passes as fill and leaves any pending sequence alone.
      queue_result(KindData, fill_byte, 1'b1);
    end else begin
      case (seq_st)
        SEQ_IDLE: begin
          if (b == IacCode) seq_st = SEQ_IAC;
          else queue_result(KindData, b, 1'b1);
        end
        SEQ_IAC: begin
          if (b == CmdWill || b == CmdWont || b == CmdDo || b == CmdDont) begin
            held_cmd = b;
            seq_st   = SEQ_NEG;
          end else begin
            // IAC IAC is an escaped 0xFF; anything else is a dropped command.
            if (b == IacCode) queue_result(KindData, IacCode, 1'b1);
            seq_st = SEQ_IDLE;
          end
        end
        default: begin
          // Refuse: WILL/WONT gets DONT, DO/DONT gets WONT, then echo the option.
          reply = (held_cmd == CmdWill || held_cmd == CmdWont) ? CmdDont : CmdWont;
          queue_result(KindReply, IacCode, 1'b0);
          queue_result(KindReply, reply, 1'b0);
          queue_result(KindReply, b, 1'b1);
          refusals_seen++;
          seq_st = SEQ_IDLE;
        end
      endcase
    end
    // Chunk end drops any partial sequence.
    if (eoc) begin
      seq_st   = SEQ_IDLE;
      held_cmd = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_out_q.size() == 0) begin
        $error("unexpected item: kind %0d byte %02h last %0d",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        err_count++;
      end else begin
        want = pending_out_q.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          err_count++;
        end
        if (m_axis_tdata !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, m_axis_tlast);
          err_count++;
        end
        results_checked++;
      end
    end
  end

  // Receiver backpressure: stall about 19 percent of the time when enabled.
  always @(posedge clk_i) begin
    m_axis_tready <= !out_stall_on || ($urandom_range(99) >= 19);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic random_chunk_end();
    return $urandom_range(99) < 8;
  endfunction

  // Offer one byte, hold it until accepted, then update the prediction.
  task automatic send_byte(input logic [7:0] b, input logic eoc);
    while (in_gaps_on && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eoc;
    do @(posedge clk_i); while (!s_axis_tready);
    filter_byte(b, eoc);
    bytes_sent++;
  endtask

  // Stop sending and wait for every predicted item, then let swallowed bytes drain.
  task automatic wait_idle();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_out_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the fill register through setup and access phases, then read it back.
  task automatic write_fill(input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegZeroFill;
    pwdata  <= {{(ApbDataW-8){1'b0}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    fill_byte = val;
    fill_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== val) begin
      $error("zero_fill_byte readback: expected %02h, got %02h", val, prdata[7:0]);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain bytes at the edges of the data range and a zero at reset fill.
  task automatic test_data_bytes();
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(NulByte, 1'b0);
  endtask

  // All four negotiation commands, option extremes, zeros inside a sequence.
  task automatic test_refusals();
    send_byte(IacCode, 1'b0);
    send_byte(CmdWill, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(IacCode, 1'b0);
    send_byte(CmdWont, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(IacCode, 1'b0);
    send_byte(NulByte, 1'b0);
    send_byte(CmdDo, 1'b0);
    send_byte(NulByte, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(IacCode, 1'b0);
    send_byte(CmdDont, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  // Escaped 0xFF and an unknown command that must be dropped silently.
  task automatic test_command_bytes();
    send_byte(IacCode, 1'b0);
    send_byte(IacCode, 1'b0);
    send_byte(IacCode, 1'b0);
    send_byte(8'hF1, 1'b0);
  endtask

  // Partial sequences cut off by a chunk end; the next byte is plain data.
  task automatic test_chunk_ends();
    send_byte(IacCode, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(IacCode, 1'b0);
    send_byte(CmdWill, 1'b1);
    send_byte(8'h42, 1'b1);
  endtask

  // Fill register at both extremes and a midrange value.
  task automatic test_fill_register();
    wait_idle();
    write_fill(8'h00);
    send_byte(NulByte, 1'b0);
    wait_idle();
    write_fill(8'hFF);
    send_byte(NulByte, 1'b1);
    wait_idle();
    write_fill(8'hA5);
    send_byte(NulByte, 1'b0);
  endtask

  // Mostly well-formed telnet traffic with random content, some noise and
  // chunk ends that break sequences, over several fill settings.
  task automatic test_random_traffic();
    logic [7:0] phase_fill [4];
    int         target;
    int         pick;
    int         run;
    bit         drained;
    phase_fill[0] = 8'($urandom_range(0, 255));
    phase_fill[1] = 8'h00;
    phase_fill[2] = 8'hFF;
    phase_fill[3] = ZeroFillReset;
    drained = 1'b0;
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_fill(phase_fill[p]);
      // Phase 1 runs both streams flat out.
      in_gaps_on   = (p != 1);
      out_stall_on = (p != 1);
      target = bytes_sent + RandomItems / 4;
      while (bytes_sent < target) begin
        if (p == 2 && !drained && bytes_sent > target - RandomItems / 8) begin
          // Hold the sender until the output side has caught up completely.
          wait_idle();
          drained = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 35) begin
          run = $urandom_range(1, 4);
          for (int k = 0; k < run; k++)
            send_byte(8'($urandom_range(1, 254)), random_chunk_end());
        end else if (pick < 62) begin
          send_byte(IacCode, random_chunk_end());
          if ($urandom_range(9) == 0) send_byte(NulByte, random_chunk_end());
          send_byte(8'(CmdWill + $urandom_range(0, 3)), random_chunk_end());
          if ($urandom_range(9) == 0) send_byte(NulByte, random_chunk_end());
          send_byte(8'($urandom_range(0, 255)), random_chunk_end());
        end else if (pick < 70) begin
          send_byte(IacCode, random_chunk_end());
          send_byte(IacCode, random_chunk_end());
        end else if (pick < 80) begin
          send_byte(IacCode, random_chunk_end());
          send_byte(8'($urandom_range(1, 250)), random_chunk_end());
        end else if (pick < 88) begin
          send_byte(NulByte, random_chunk_end());
        end else begin
          send_byte(8'($urandom_range(0, 255)), random_chunk_end());
        end
      end
    end
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tlast    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    seq_st          = SEQ_IDLE;
    held_cmd        = '0;
    fill_byte       = ZeroFillReset;
    err_count       = 0;
    bytes_sent      = 0;
    results_checked = 0;
    refusals_seen   = 0;
    fill_writes     = 0;
    in_gaps_on      = 1'b1;
    out_stall_on    = 1'b1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_data_bytes();
    test_refusals();
    test_command_bytes();
    test_chunk_ends();
    test_fill_register();
    test_random_traffic();

    wait_idle();
    if (pending_out_q.size() != 0) begin
      $error("%0d expected items never arrived", pending_out_q.size());
      err_count++;
    end

    $display("Covered %0d input bytes, %0d output items checked, %0d refusals,",
             bytes_sent, results_checked, refusals_seen);
    $display("%0d fill register writes including 0x00 and 0xFF.", fill_writes);
    if (err_count == 0) begin
      $display("telnet_iac_filter_tb: done, clean");
    end else begin
      $display("telnet_iac_filter_tb: done, errors");
    end
    $finish;
  end

endmodule
